/* src/dzft_pkg.sv */
package dzft_pkg;

  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DEAD_ZONE_X     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_STEP_X      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_STEP_Y      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_AIR_WINDOW_Y    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BOUND_EASE_STEP = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_LINES    = 3'd5;

  localparam logic CMD_INIT  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  localparam logic [30:0] RST_DEAD_ZONE_X     = 31'h0008_0000;
  localparam logic [30:0] RST_MAX_STEP_X      = 31'h0010_0000;
  localparam logic [30:0] RST_MAX_STEP_Y      = 31'h0018_0000;
  localparam logic [30:0] RST_AIR_WINDOW_Y    = 31'h0020_0000;
  localparam logic [7:0]  RST_BOUND_EASE_STEP = 8'd2;
  localparam logic [9:0]  RST_SCREEN_LINES    = 10'd224;

  // fraction bits of the 16.16 format and window decay shift
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DecayShift = 3;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] adjust_y;
    logic              airborne;
    logic signed [31:0] prev_screen_top;
    logic signed [31:0] zone_top;
    logic signed [31:0] zone_bottom;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] limit_top;
    logic signed [31:0] limit_bottom;
    logic signed [31:0] speed_y;
  } out_item_t;

  typedef struct packed {
    logic [30:0] dead_zone_x;
    logic [30:0] max_step_x;
    logic [30:0] max_step_y;
    logic [30:0] air_window_y;
    logic [7:0]  bound_ease_step;
    logic [9:0]  screen_lines;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] window_y;
    logic signed [31:0] last_speed_y;
    logic signed [31:0] top_limit;
    logic signed [31:0] bottom_limit;
  } trk_state_t;

  // dead zone follow on one axis, move clamped to +/- cap
  function automatic logic signed [31:0] follow_axis(
    input logic signed [31:0] pos,
    input logic signed [31:0] tgt,
    input logic signed [31:0] win,
    input logic signed [31:0] cap
  );
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] ncap;
    logic signed [31:0] d;
    logic signed [31:0] res;
    hi   = pos + win;
    lo   = pos - win;
    ncap = -cap;
    res  = pos;
    d    = '0;
    if (tgt > hi) begin
      d = tgt - pos - win;
      if (cap < d) begin
        d = cap;
      end
      res = pos + d;
    end else if (tgt < lo) begin
      d = tgt + win - pos;
      if (d < ncap) begin
        d = ncap;
      end
      res = pos + d;
    end
    return res;
  endfunction

endpackage

/* src/dzft_step.sv */
module dzft_step (
  input  dzft_pkg::cfg_t       cfg,
  input  dzft_pkg::trk_state_t st,
  input  dzft_pkg::in_item_t   item,
  output dzft_pkg::trk_state_t st_nxt,
  output dzft_pkg::out_item_t  res
);
  import dzft_pkg::*;

  logic signed [31:0] step_s;
  logic signed [31:0] sb;
  logic signed [31:0] vpix;
  logic               vneg;
  logic               vpos;
  logic signed [31:0] top_a;
  logic signed [31:0] top_b;
  logic signed [31:0] bot_a;
  logic signed [31:0] bot_b;
  logic signed [31:0] win;
  logic signed [31:0] win_dec;
  logic signed [31:0] tgt_y;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;

  assign step_s = signed'({24'd0, cfg.bound_ease_step});
  assign sb     = item.prev_screen_top + signed'({22'd0, cfg.screen_lines});
  assign vpix   = st.last_speed_y >>> FracBits;
  assign vneg   = st.last_speed_y[31];
  assign vpos   = !vneg && (st.last_speed_y != '0);

  // top limit easing
  always_comb begin
    top_a = st.top_limit;
    if (top_a < item.zone_top) begin
      top_a = (top_a < item.prev_screen_top) ? item.prev_screen_top
                                             : item.prev_screen_top + step_s;
    end
    top_b = top_a;
    if (item.zone_top < top_a) begin
      if (!(top_a < item.prev_screen_top)) begin
        top_b = top_a - step_s;
        if (vneg) begin
          top_b = top_b + vpix;
          if (top_b < item.zone_top) begin
            top_b = item.zone_top;
          end
        end
      end else begin
        top_b = item.zone_top;
      end
    end
  end

  // bottom limit easing
  always_comb begin
    bot_a = st.bottom_limit;
    if (item.zone_bottom < bot_a) begin
      bot_a = (!(sb < bot_a)) ? bot_a - step_s : sb;
    end
    bot_b = bot_a;
    if (bot_a < item.zone_bottom) begin
      if (!(sb < bot_a)) begin
        bot_b = bot_a + step_s;
        if (vpos) begin
          bot_b = bot_b + vpix;
          if (item.zone_bottom < bot_b) begin
            bot_b = item.zone_bottom;
          end
        end
      end else begin
        bot_b = item.zone_bottom;
      end
    end
  end

  assign win   = item.airborne ? signed'({1'b0, cfg.air_window_y}) : st.window_y;
  assign tgt_y = item.target_y - item.adjust_y;
  assign new_x = follow_axis(st.pos_x, item.target_x,
                             signed'({1'b0, cfg.dead_zone_x}),
                             signed'({1'b0, cfg.max_step_x}));
  assign new_y = follow_axis(st.pos_y, tgt_y, win,
                             signed'({1'b0, cfg.max_step_y}));

  // grounded window decays by an eighth, floored at zero
  always_comb begin
    win_dec = win;
    if (!item.airborne) begin
      win_dec = win - (win >>> DecayShift);
      if (win_dec[31]) begin
        win_dec = '0;
      end
    end
  end

  always_comb begin
    if (item.cmd == CMD_INIT) begin
      st_nxt.pos_x        = item.target_x;
      st_nxt.pos_y        = item.target_y;
      st_nxt.window_y     = '0;
      st_nxt.last_speed_y = '0;
      st_nxt.top_limit    = item.zone_top;
      st_nxt.bottom_limit = item.zone_bottom;
    end else begin
      st_nxt.pos_x        = new_x;
      st_nxt.pos_y        = new_y;
      st_nxt.window_y     = win_dec;
      st_nxt.last_speed_y = new_y - st.pos_y;
      st_nxt.top_limit    = top_b;
      st_nxt.bottom_limit = bot_b;
    end
  end

  assign res.view_x       = st_nxt.pos_x;
  assign res.view_y       = st_nxt.pos_y;
  assign res.limit_top    = st_nxt.top_limit;
  assign res.limit_bottom = st_nxt.bottom_limit;
  assign res.speed_y      = st_nxt.last_speed_y;

endmodule

/* src/deadzone_follow_tracker_core.sv */
// Viewport follow tracker. Each input beat is either an init command, which
// loads position and viewport limits, or a frame step, which eases the top
// and bottom limits toward the zone limits and then moves the viewport
// toward the target inside horizontal and vertical dead zones, each move
// clamped per axis. Every beat yields exactly one result beat. Throughput is
// one beat per clock while the output is not stalled, which the state update
// loop allows; each beat passes the input register, then the result register,
// before its result is offered. Configuration writes are always taken (cfg_ready
// is tied high) and should only be issued while the tracker is idle.
module deadzone_follow_tracker_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  dzft_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output dzft_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dzft_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);
  import dzft_pkg::*;

  // configuration registers
  cfg_t       cfg_r;

  // input register stage
  logic       in_vld_r;
  in_item_t   in_item_r;

  // tracker state, updated once per processed beat
  trk_state_t st_r;
  trk_state_t st_nxt;

  // result register stage
  logic       out_vld_r;
  out_item_t  out_item_r;
  out_item_t  res;

  logic       advance;

  // the held beat moves on whenever the result slot is free or being drained
  assign advance  = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && !advance;

  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  dzft_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (in_item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // register file, values masked to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone_x     <= RST_DEAD_ZONE_X;
      cfg_r.max_step_x      <= RST_MAX_STEP_X;
      cfg_r.max_step_y      <= RST_MAX_STEP_Y;
      cfg_r.air_window_y    <= RST_AIR_WINDOW_Y;
      cfg_r.bound_ease_step <= RST_BOUND_EASE_STEP;
      cfg_r.screen_lines    <= RST_SCREEN_LINES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEAD_ZONE_X:     cfg_r.dead_zone_x     <= cfg_data[30:0];
        REG_MAX_STEP_X:      cfg_r.max_step_x      <= cfg_data[30:0];
        REG_MAX_STEP_Y:      cfg_r.max_step_y      <= cfg_data[30:0];
        REG_AIR_WINDOW_Y:    cfg_r.air_window_y    <= cfg_data[30:0];
        REG_BOUND_EASE_STEP: cfg_r.bound_ease_step <= cfg_data[7:0];
        REG_SCREEN_LINES:    cfg_r.screen_lines    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // input stage: takes a new beat whenever it is not stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
  end

  // state and result update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r      <= st_nxt;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

endmodule

/* verif/tb_deadzone_follow_tracker_core.sv */
`timescale 1ns / 1ps

module tb_deadzone_follow_tracker_core;
  import dzft_pkg::*;

  // clock, reset and all block inputs start at known values
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  deadzone_follow_tracker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // tracker shadow: registers and state as the block should hold them
  cfg_t regs;
  logic [31:0] cam_x, cam_y, win_y, spd_y, lim_top, lim_bot;

  // viewport results still owed by the block, oldest first
  out_item_t pending_views[$];

  int failures = 0;
  int items_sent = 0;
  int views_checked = 0;
  int cfg_writes = 0;

  // idling controls shared by the sender and the receiver
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;
  int hold_len = 0;

  // two's complement compare on 32-bit words
  function automatic bit below(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // move one axis toward its aim, outside the dead zone only, step capped
  function automatic logic [31:0] chase_axis(input logic [31:0] at, input logic [31:0] aim,
                                             input logic [31:0] slack,
                                             input logic [31:0] cap);
    logic [31:0] d;
    logic [31:0] res;
    res = at;
    if (below(at + slack, aim)) begin
      d = aim - at - slack;
      if (below(cap, d)) d = cap;
      res = at + d;
    end else if (below(aim, at - slack)) begin
      d = aim + slack - at;
      if (below(d, 32'd0 - cap)) d = 32'd0 - cap;
      res = at + d;
    end
    return res;
  endfunction

  // apply one accepted beat to the shadow state and return the viewport it yields
  function automatic out_item_t advance_tracker(input in_item_t it);
    out_item_t r;
    logic [31:0] old_y, aim_y, scr_bot, vpix, step;
    logic vneg, vpos;
    if (it.cmd == CMD_INIT) begin
      cam_x = it.target_x;
      cam_y = it.target_y;
      win_y = '0;
      spd_y = '0;
      lim_top = it.zone_top;
      lim_bot = it.zone_bottom;
    end else begin
      old_y = cam_y;
      scr_bot = it.prev_screen_top + {22'd0, regs.screen_lines};
      vpix = $signed(spd_y) >>> FracBits;
      vneg = spd_y[31];
      vpos = !vneg && (spd_y != '0);
      step = {24'd0, regs.bound_ease_step};

      // top limit: snap up to the screen top, or ease down by step and upward speed
      if (below(lim_top, it.zone_top))
        lim_top = below(lim_top, it.prev_screen_top) ? it.prev_screen_top
                                                     : it.prev_screen_top + step;
      if (below(it.zone_top, lim_top)) begin
        if (!below(lim_top, it.prev_screen_top)) begin
          lim_top = lim_top - step;
          if (vneg) begin
            lim_top = lim_top + vpix;
            if (below(lim_top, it.zone_top)) lim_top = it.zone_top;
          end
        end else begin
          lim_top = it.zone_top;
        end
      end

      // bottom limit mirrors it against the screen bottom
      if (below(it.zone_bottom, lim_bot)) begin
        if (!below(scr_bot, lim_bot)) lim_bot = lim_bot - step;
        else lim_bot = scr_bot;
      end
      if (below(lim_bot, it.zone_bottom)) begin
        if (!below(scr_bot, lim_bot)) begin
          lim_bot = lim_bot + step;
          if (vpos) begin
            lim_bot = lim_bot + vpix;
            if (below(it.zone_bottom, lim_bot)) lim_bot = it.zone_bottom;
          end
        end else begin
          lim_bot = it.zone_bottom;
        end
      end

      if (it.airborne) win_y = {1'b0, regs.air_window_y};
      cam_x = chase_axis(cam_x, it.target_x, {1'b0, regs.dead_zone_x},
                         {1'b0, regs.max_step_x});
      aim_y = it.target_y - it.adjust_y;
      cam_y = chase_axis(cam_y, aim_y, win_y, {1'b0, regs.max_step_y});
      // grounded: window shrinks by an eighth, never below zero
      if (!it.airborne) begin
        win_y = win_y - 32'($signed(win_y) >>> DecayShift);
        if (win_y[31]) win_y = '0;
      end
      spd_y = cam_y - old_y;
    end
    r.view_x = cam_x;
    r.view_y = cam_y;
    r.limit_top = lim_top;
    r.limit_bottom = lim_bot;
    r.speed_y = spd_y;
    return r;
  endfunction

  function automatic in_item_t pack_item(input logic cmd, input logic [31:0] tx,
                                         input logic [31:0] ty, input logic [31:0] ay,
                                         input logic air, input logic [31:0] pst,
                                         input logic [31:0] zt, input logic [31:0] zb);
    in_item_t it;
    it.cmd = cmd;
    it.target_x = tx;
    it.target_y = ty;
    it.adjust_y = ay;
    it.airborne = air;
    it.prev_screen_top = pst;
    it.zone_top = zt;
    it.zone_bottom = zb;
    return it;
  endfunction

  // uniform offset in [-span, span], wrapping at 32 bits
  function automatic logic [31:0] jitter(input int unsigned span);
    return $urandom_range(2 * span, 0) - span;
  endfunction

  // how far a target strays from the viewport, from inside the zone to far away
  function automatic int unsigned reach();
    case ($urandom_range(0, 3))
      0: return 32'h0000_8000;
      1: return 32'h0008_0000;
      2: return 32'h0020_0000;
      default: return 32'h0100_0000;
    endcase
  endfunction

  // frame step near the current viewport, with a full-width random frame or init now and then
  function automatic in_item_t make_frame();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.cmd = CMD_FRAME;
    it.airborne = 1'($urandom_range(0, 1));
    if (pick < 15) begin
      it.cmd = ($urandom_range(0, 1) != 0) ? CMD_FRAME : CMD_INIT;
      it.target_x = $urandom;
      it.target_y = $urandom;
      it.adjust_y = $urandom;
      it.prev_screen_top = $urandom;
      it.zone_top = $urandom;
      it.zone_bottom = $urandom;
    end else begin
      it.adjust_y = (pick < 30) ? $urandom : jitter(32'h0004_0000);
      it.target_x = cam_x + jitter(reach());
      it.target_y = cam_y + it.adjust_y + jitter(reach());
      // screen top either near the top limit or one screen above the bottom limit
      if ($urandom_range(0, 1))
        it.prev_screen_top = lim_top + jitter(16);
      else
        it.prev_screen_top = lim_bot - {22'd0, regs.screen_lines} + jitter(16);
      it.zone_top = lim_top + jitter(24);
      it.zone_bottom = lim_bot + jitter(24);
    end
    return it;
  endfunction

  function automatic in_item_t make_init();
    in_item_t it;
    it.cmd = CMD_INIT;
    it.target_x = ($urandom_range(0, 3) == 0) ? $urandom : jitter(32'h0100_0000);
    it.target_y = ($urandom_range(0, 3) == 0) ? $urandom : jitter(32'h0100_0000);
    it.adjust_y = $urandom;
    it.airborne = 1'($urandom_range(0, 1));
    it.prev_screen_top = $urandom;
    it.zone_top = jitter(512);
    it.zone_bottom = it.zone_top + $urandom_range(0, 400);
    return it;
  endfunction

  // offer one beat, after a random gap when the sender idles; valid stays high so back-to-back beats need no toggle
  task automatic send_beat(input in_item_t item);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_views.push_back(advance_tracker(item));
    items_sent++;
  endtask

  // drop valid and wait for every owed result, bounded
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_views.size() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_views.size() != 0) begin
      $error("%0d result beats never arrived", pending_views.size());
      failures++;
      pending_views.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // one register write; valid is left high for a following write
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_DEAD_ZONE_X:     regs.dead_zone_x = value[30:0];
      REG_MAX_STEP_X:      regs.max_step_x = value[30:0];
      REG_MAX_STEP_Y:      regs.max_step_y = value[30:0];
      REG_AIR_WINDOW_Y:    regs.air_window_y = value[30:0];
      REG_BOUND_EASE_STEP: regs.bound_ease_step = value[7:0];
      REG_SCREEN_LINES:    regs.screen_lines = value[9:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // rewrite every register, only once the tracker has gone idle
  task automatic set_tracker_regs(input logic [31:0] dzx, input logic [31:0] msx,
                                  input logic [31:0] msy, input logic [31:0] awy,
                                  input logic [31:0] ease, input logic [31:0] scr);
    drain();
    put_reg(REG_DEAD_ZONE_X, dzx);
    put_reg(REG_MAX_STEP_X, msx);
    put_reg(REG_MAX_STEP_Y, msy);
    put_reg(REG_AIR_WINDOW_Y, awy);
    put_reg(REG_BOUND_EASE_STEP, ease);
    put_reg(REG_SCREEN_LINES, scr);
    cfg_valid <= 1'b0;
  endtask

  // both sides, one side or neither idling, chosen per stretch of beats
  task automatic pick_idle_mode();
    int mode;
    mode = $urandom_range(0, 3);
    tx_idle = mode[0];
    rx_idle = mode[1];
  endtask

  // field extremes from reset state, init ignoring its unused fields, wrapping sums
  task automatic test_directed_extremes();
    send_beat(pack_item(CMD_FRAME, '0, '0, '0, 1'b0, '0, '0, '0));
    send_beat(pack_item(CMD_INIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_beat(pack_item(CMD_FRAME, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_beat(pack_item(CMD_FRAME, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_beat(pack_item(CMD_FRAME, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1,
                        32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
    drain();
  endtask

  // dead zone hold, capped moves both ways, airborne window then grounded decay
  task automatic test_follow_cases();
    send_beat(pack_item(CMD_INIT, 32'h0010_0000, 32'h0010_0000, '0, 1'b0, '0, '0, 32'd224));
    send_beat(pack_item(CMD_FRAME, 32'h0014_0000, 32'h0010_0000, '0, 1'b0, '0, '0, 32'd224));
    send_beat(pack_item(CMD_FRAME, 32'h0090_0000, 32'h0010_0000, '0, 1'b0, '0, '0, 32'd224));
    send_beat(pack_item(CMD_FRAME, 32'hFF00_0000, 32'h0010_0000, '0, 1'b0, '0, '0, 32'd224));
    send_beat(pack_item(CMD_FRAME, 32'h0000_0000, 32'hFF00_0000, 32'h0001_0000, 1'b1,
                        '0, '0, 32'd224));
    send_beat(pack_item(CMD_FRAME, 32'h0000_0000, 32'hFF00_0000, '0, 1'b0, '0, '0, 32'd224));
    send_beat(pack_item(CMD_FRAME, 32'h0000_0000, 32'h0004_0000, '0, 1'b0, '0, '0, 32'd224));
    drain();
  endtask

  // limits snapping to the screen, easing by step, sped up by last vertical move
  task automatic test_limit_easing();
    send_beat(pack_item(CMD_INIT, '0, '0, '0, 1'b0, '0, 32'd100, 32'd300));
    send_beat(pack_item(CMD_FRAME, '0, '0, '0, 1'b0, 32'd90, 32'd120, 32'd300));
    send_beat(pack_item(CMD_FRAME, '0, 32'hFC00_0000, '0, 1'b1, 32'd200, 32'd50, 32'd250));
    send_beat(pack_item(CMD_FRAME, '0, 32'hFC00_0000, '0, 1'b1, 32'd40, 32'd50, 32'd250));
    send_beat(pack_item(CMD_FRAME, '0, 32'h0400_0000, '0, 1'b0, 32'd40, 32'd30, 32'd400));
    send_beat(pack_item(CMD_FRAME, '0, 32'h0400_0000, '0, 1'b0, 32'd200, 32'd30, 32'd500));
    drain();
  endtask

  // several register settings: all zero, all ones masked to width, two random sets, then reset values
  task automatic test_config_sweep();
    set_tracker_regs('0, '0, '0, '0, '0, '0);
    for (int i = 0; i < 50; i++) send_beat((i % 20 == 0) ? make_init() : make_frame());
    set_tracker_regs('1, '1, '1, '1, '1, '1);
    for (int i = 0; i < 50; i++) send_beat((i % 20 == 0) ? make_init() : make_frame());
    for (int k = 0; k < 2; k++) begin
      pick_idle_mode();
      set_tracker_regs(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40_0000),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40_0000),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40_0000),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40_0000),
                       $urandom, $urandom);
      for (int i = 0; i < 50; i++) send_beat((i % 20 == 0) ? make_init() : make_frame());
    end
    set_tracker_regs({1'b0, RST_DEAD_ZONE_X}, {1'b0, RST_MAX_STEP_X}, {1'b0, RST_MAX_STEP_Y},
                     {1'b0, RST_AIR_WINDOW_Y}, {24'd0, RST_BOUND_EASE_STEP},
                     {22'd0, RST_SCREEN_LINES});
  endtask

  // long runs of frames with an occasional re-init, idling mode changing per stretch
  task automatic test_random_follow(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) pick_idle_mode();
      send_beat(($urandom_range(0, 19) == 0) ? make_init() : make_frame());
    end
    drain();
  endtask

  // receiver holds off while the sender keeps pushing, so the input must stall
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_len = 80;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_beat(make_frame());
    drain();
  endtask

  // receiver: random stall before each result beat, or one long hold on request
  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1 && !hold_req);
    end
  end

  // result checker: every accepted beat against the oldest owed viewport
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_views.size() == 0) begin
        $error("unexpected result beat %h", out_data);
        failures++;
      end else begin
        want = pending_views.pop_front();
        views_checked++;
        if (out_data.view_x !== want.view_x) begin
          $error("view_x expected %h got %h", want.view_x, out_data.view_x);
          failures++;
        end
        if (out_data.view_y !== want.view_y) begin
          $error("view_y expected %h got %h", want.view_y, out_data.view_y);
          failures++;
        end
        if (out_data.limit_top !== want.limit_top) begin
          $error("limit_top expected %h got %h", want.limit_top, out_data.limit_top);
          failures++;
        end
        if (out_data.limit_bottom !== want.limit_bottom) begin
          $error("limit_bottom expected %h got %h", want.limit_bottom, out_data.limit_bottom);
          failures++;
        end
        if (out_data.speed_y !== want.speed_y) begin
          $error("speed_y expected %h got %h", want.speed_y, out_data.speed_y);
          failures++;
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[deadzone_follow_tracker_core] ERROR");
    $finish;
  end

  initial begin
    regs.dead_zone_x = RST_DEAD_ZONE_X;
    regs.max_step_x = RST_MAX_STEP_X;
    regs.max_step_y = RST_MAX_STEP_Y;
    regs.air_window_y = RST_AIR_WINDOW_Y;
    regs.bound_ease_step = RST_BOUND_EASE_STEP;
    regs.screen_lines = RST_SCREEN_LINES;
    cam_x = '0;
    cam_y = '0;
    win_y = '0;
    spd_y = '0;
    lim_top = '0;
    lim_bot = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_follow_cases();
    test_limit_easing();
    test_config_sweep();
    test_random_follow(450);
    test_backpressure();

    drain();
    repeat (10) @(posedge clk);
    $display("tracker run: %0d beats in (inits and frames), %0d results compared",
             items_sent, views_checked);
    $display("%0d register writes over zero, full-width, random and reset settings",
             cfg_writes);
    if (failures == 0) begin
      $display("[deadzone_follow_tracker_core] OK");
    end else begin
      $display("[deadzone_follow_tracker_core] ERROR");
    end
    $finish;
  end

endmodule
